### design/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg - keypad scan debouncer shared definitions
// Field widths, register indexes, mode encoding and the key map.
// ----------------------------------------------------------------------------
package kpd_pkg;

    localparam int unsigned NUM_COLS  = 4;
    localparam int unsigned ROW_W     = 3;
    localparam int unsigned KEY_W     = 4;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned CFG_W     = 4;
    localparam int unsigned IN_DATA_W  = 16;  // 12 field bits, padded to bytes
    localparam int unsigned OUT_DATA_W = 8;   // 6 field bits, padded to bytes

    // configuration register indexes
    localparam logic REG_PRESS_SCANS   = 1'b0;
    localparam logic REG_RELEASE_SCANS = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CFG_W-1:0] SCANS_RESET = 4'd4;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_DEBOUNCE = 2'd1,
        MODE_HELD     = 2'd2
    } mode_t;

    // key code for a column and a single active row
    function automatic logic [KEY_W-1:0] key_code(input logic [1:0] col,
                                                   input logic [1:0] row);
        logic [KEY_W-1:0] code;
        code = '0;
        unique case (col)
            2'd0: code = KEY_W'(4'd1 + {2'b00, row});
            2'd1: code = KEY_W'(4'd4 + {2'b00, row});
            2'd2: code = KEY_W'(4'd7 + {2'b00, row});
            2'd3: begin
                case (row)
                    2'd0:    code = 4'd10;
                    2'd1:    code = 4'd0;
                    default: code = 4'd11;
                endcase
            end
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

### design/keypad_scan_debouncer.sv
// ----------------------------------------------------------------------------
// keypad_scan_debouncer - 4x3 matrix keypad scan decoder with debounce
// One scan snapshot in, one result out: debounced key with repeat while held,
// and a sleep request on scans with no valid key while idle.
// ----------------------------------------------------------------------------
//
//  channel  | ports              | payload (low bit first)
//  ---------+--------------------+---------------------------------------------
//  scan in  | s_tvalid/s_tready  | s_tdata: col0_rows, col1_rows, col2_rows,
//           |                    |          col3_rows (3 bits each)
//  result   | m_tvalid/m_tready  | m_tdata: send_key, key_value[3:0],
//           |                    |          sleep_request
//  config   | cfg_wr_en          | cfg_addr 0 press_scans, 1 release_scans
//
//  Two stages: an input register, then decode and mode update into the result
//  register. One scan is taken every cycle while the result output is not stalled.
//  The result register is the only place a stall is felt: the input stage
//  moves whenever the result register is empty or being taken.
//  aresetn (synchronous, active low) clears the valid flags, the mode, the
//  candidate and the counter; both thresholds go back to 4.
// ----------------------------------------------------------------------------
module keypad_scan_debouncer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // scan input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] col0_rows, [5:3] col1_rows, [8:6] col2_rows, [11:9] col3_rows
    input  logic [kpd_pkg::IN_DATA_W-1:0]  s_tdata,
    // result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] send_key, [4:1] key_value, [5] sleep_request
    output logic [kpd_pkg::OUT_DATA_W-1:0] m_tdata,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic                           cfg_addr,
    input  logic [kpd_pkg::CFG_W-1:0]      cfg_wdata
);

    // ---- configuration -----------------------------------------------------
    logic [kpd_pkg::CFG_W-1:0] press_scans_reg;
    logic [kpd_pkg::CFG_W-1:0] release_scans_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_scans_reg   <= kpd_pkg::SCANS_RESET;
            release_scans_reg <= kpd_pkg::SCANS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                kpd_pkg::REG_PRESS_SCANS:   press_scans_reg   <= cfg_wdata;
                kpd_pkg::REG_RELEASE_SCANS: release_scans_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---- pipeline control --------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;       // stage 1 may move into the result register
    logic in_fire;       // stage 1 holds a scan that moves this cycle

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = in_valid_reg && advance;

    // ---- stage 1: input register -------------------------------------------
    logic [kpd_pkg::ROW_W-1:0] rows_reg [kpd_pkg::NUM_COLS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            for (int c = 0; c < kpd_pkg::NUM_COLS; c++) begin
                rows_reg[c] <= s_tdata[c*kpd_pkg::ROW_W +: kpd_pkg::ROW_W];
            end
        end
    end

    // ---- decode: first column with any row set -----------------------------
    logic                      scan_valid;
    logic [kpd_pkg::KEY_W-1:0] scan_key;

    always_comb begin
        logic found;
        found      = 1'b0;
        scan_valid = 1'b0;
        scan_key   = '0;
        for (int c = 0; c < kpd_pkg::NUM_COLS; c++) begin
            if (!found && (rows_reg[c] != '0)) begin
                found = 1'b1;
                case (rows_reg[c])
                    3'b001: begin
                        scan_valid = 1'b1;
                        scan_key   = kpd_pkg::key_code(2'(c), 2'd0);
                    end
                    3'b010: begin
                        scan_valid = 1'b1;
                        scan_key   = kpd_pkg::key_code(2'(c), 2'd1);
                    end
                    3'b100: begin
                        scan_valid = 1'b1;
                        scan_key   = kpd_pkg::key_code(2'(c), 2'd2);
                    end
                    default: scan_valid = 1'b0;   // chord in one column
                endcase
            end
        end
    end

    // ---- mode machine ------------------------------------------------------
    kpd_pkg::mode_t            mode_reg, mode_next;
    logic [kpd_pkg::KEY_W-1:0] cand_key_reg, cand_key_next;
    logic                      cand_valid_reg, cand_valid_next;
    logic [kpd_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      send_next, sleep_next;
    logic [kpd_pkg::KEY_W-1:0] value_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= kpd_pkg::MODE_IDLE;
            cand_key_reg   <= '0;
            cand_valid_reg <= 1'b0;
            count_reg      <= '0;
        end else if (in_fire) begin
            mode_reg       <= mode_next;
            cand_key_reg   <= cand_key_next;
            cand_valid_reg <= cand_valid_next;
            count_reg      <= count_next;
        end
    end

    always_comb begin
        logic [kpd_pkg::CNT_W-1:0] count_inc;
        count_inc = (count_reg == kpd_pkg::CNT_MAX) ? kpd_pkg::CNT_MAX
                                                    : count_reg + 1'b1;
        mode_next       = mode_reg;
        cand_key_next   = cand_key_reg;
        cand_valid_next = cand_valid_reg;
        count_next      = count_reg;
        send_next       = 1'b0;
        sleep_next      = 1'b0;
        value_next      = '0;
        unique case (mode_reg)
            kpd_pkg::MODE_HELD: begin
                // repeat the held key until enough scans without a valid key in a row
                count_next = scan_valid ? '0 : count_inc;
                if (!scan_valid && (count_next >= release_scans_reg)) begin
                    mode_next       = kpd_pkg::MODE_IDLE;
                    count_next      = '0;
                    cand_valid_next = 1'b0;
                end else begin
                    send_next  = 1'b1;
                    value_next = cand_key_reg;
                end
            end
            default: begin
                // idle, debounce, and the unused code (acts as idle)
                if (!scan_valid) begin
                    sleep_next      = (mode_reg != kpd_pkg::MODE_DEBOUNCE);
                    cand_valid_next = 1'b0;
                    count_next      = '0;
                end else begin
                    if ((mode_reg == kpd_pkg::MODE_DEBOUNCE) && cand_valid_reg &&
                        (scan_key == cand_key_reg)) begin
                        count_next = count_inc;
                    end else begin
                        cand_key_next   = scan_key;
                        cand_valid_next = 1'b1;
                        count_next      = 4'd1;
                    end
                    mode_next = kpd_pkg::MODE_DEBOUNCE;
                    if (count_next >= press_scans_reg) begin
                        mode_next  = kpd_pkg::MODE_HELD;
                        count_next = '0;
                        send_next  = 1'b1;
                        value_next = cand_key_next;
                    end
                end
            end
        endcase
    end

    // ---- stage 2: result register ------------------------------------------
    logic                      send_reg;
    logic                      sleep_reg;
    logic [kpd_pkg::KEY_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            send_reg  <= send_next;
            sleep_reg <= sleep_next;
            value_reg <= value_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, sleep_reg, value_reg, send_reg};

    // ---- assertions --------------------------------------------------------
    // a scan never both sends a key and requests sleep
    a_send_xor_sleep: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(send_reg && sleep_reg))
        else $error("send_key and sleep_request both set");

    // sleep only comes from a scan taken while idle
    a_sleep_idle_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (mode_reg != kpd_pkg::MODE_IDLE)) |=> !sleep_reg)
        else $error("sleep requested outside idle");

    // the held mode always carries a valid candidate
    a_held_cand: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == kpd_pkg::MODE_HELD) |-> cand_valid_reg)
        else $error("held mode without a candidate key");

    // a sent key is a real key code, an unsent one reads zero
    a_key_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (send_reg ? (value_reg <= 4'd11) : (value_reg == '0)))
        else $error("key_value out of range");

endmodule
